### rtl/lcfr_pkg.sv
// Types, codes and constants shared by the frame receiver modules.
`timescale 1ns / 1ps

package lcfr_pkg;

  localparam logic [7:0] LEN_MIN    = 8'd3;
  localparam logic [7:0] SUM_INVERT = 8'hFF;

  localparam logic [2:0] KIND_FLUSH   = 3'd0;
  localparam logic [2:0] KIND_LENGTH  = 3'd1;
  localparam logic [2:0] KIND_TYPE    = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_GOOD    = 3'd4;
  localparam logic [2:0] KIND_BAD     = 3'd5;
  localparam logic [2:0] KIND_SHORT   = 3'd6;

  typedef struct packed {
    logic [7:0] byte_position;
    logic [7:0] frame_length;
    logic [7:0] running_sum;
    logic [7:0] held_type;
  } frame_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [7:0] payload_index;
    logic [7:0] frame_type;
    logic [7:0] payload_length;
    logic       frame_end;
  } frame_result_t;

endpackage

### rtl/length_checksum_frame_receiver_unit.sv
// An accepted item passes through the input register and then the result register to the output.
// Throughput: one item per cycle without stalls; the 8-bit sum and position update per item.
// The input register keeps taking items while a result waits, until both stages are full.
// Reset (rst, synchronous, active high) empties both stages and clears the frame state,
// leaving the receiver awaiting a length byte.
`timescale 1ns / 1ps

module length_checksum_frame_receiver_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       flush,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] byte_value,
  output logic [7:0] payload_index,
  output logic [7:0] frame_type,
  output logic [7:0] payload_length,
  output logic       frame_end
);
  import lcfr_pkg::*;

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_flush;
  logic          s1_advance;
  frame_state_t  state;
  frame_state_t  state_next;
  frame_result_t step_res;
  frame_result_t res;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  lcfr_step u_step (
    .cur     (state),
    .rx_byte (s1_byte),
    .flush   (s1_flush),
    .nxt     (state_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= rx_byte;
      s1_flush <= flush;
    end
    if (s1_advance) begin
      res <= step_res;
    end
  end

  assign kind           = res.kind;
  assign byte_value     = res.byte_value;
  assign payload_index  = res.payload_index;
  assign frame_type     = res.frame_type;
  assign payload_length = res.payload_length;
  assign frame_end      = res.frame_end;

endmodule

### rtl/lcfr_step.sv
// Per-byte frame decode: next frame state and the result for one item.
`timescale 1ns / 1ps

module lcfr_step (
  input  lcfr_pkg::frame_state_t  cur,
  input  logic [7:0]              rx_byte,
  input  logic                    flush,
  output lcfr_pkg::frame_state_t  nxt,
  output lcfr_pkg::frame_result_t res
);
  import lcfr_pkg::*;

  logic [8:0] pos_plus_one;
  logic [7:0] plen_cur;

  assign pos_plus_one = {1'b0, cur.byte_position} + 9'd1;
  assign plen_cur     = cur.frame_length - LEN_MIN;

  always_comb begin
    nxt = cur;
    res.kind           = KIND_FLUSH;
    res.byte_value     = rx_byte;
    res.payload_index  = 8'd0;
    res.frame_type     = 8'd0;
    res.payload_length = 8'd0;
    res.frame_end      = 1'b0;
    if (flush) begin
      nxt = '0;
      res.kind       = KIND_FLUSH;
      res.byte_value = 8'd0;
      res.frame_end  = 1'b1;
    end else if (cur.byte_position == 8'd0) begin
      if (rx_byte < LEN_MIN) begin
        res.kind      = KIND_SHORT;
        res.frame_end = 1'b1;
      end else begin
        res.kind           = KIND_LENGTH;
        res.payload_length = rx_byte - LEN_MIN;
        nxt.frame_length   = rx_byte;
        nxt.running_sum    = rx_byte;
        nxt.held_type      = 8'd0;
        nxt.byte_position  = 8'd1;
      end
    end else if (cur.byte_position == 8'd1) begin
      res.kind           = KIND_TYPE;
      res.frame_type     = rx_byte;
      res.payload_length = plen_cur;
      nxt.held_type      = rx_byte;
      nxt.running_sum    = cur.running_sum + rx_byte;
      nxt.byte_position  = 8'd2;
    end else begin
      res.frame_type     = cur.held_type;
      res.payload_length = plen_cur;
      if (pos_plus_one >= {1'b0, cur.frame_length}) begin
        res.kind      = (rx_byte == (cur.running_sum ^ SUM_INVERT)) ? KIND_GOOD : KIND_BAD;
        res.frame_end = 1'b1;
        nxt           = '0;
      end else begin
        res.kind          = KIND_PAYLOAD;
        res.payload_index = cur.byte_position - 8'd2;
        nxt.running_sum   = cur.running_sum + rx_byte;
        nxt.byte_position = pos_plus_one[7:0];
      end
    end
  end

endmodule

### rtl/lcfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`timescale 1ns / 1ps

module lcfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] byte_value,
  input logic [7:0] payload_index,
  input logic [7:0] frame_type,
  input logic [7:0] payload_length,
  input logic       frame_end
);
  import lcfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(byte_value))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_SHORT)
    else $error("undefined result kind");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_end == (kind == KIND_FLUSH || kind == KIND_GOOD ||
                                kind == KIND_BAD || kind == KIND_SHORT))
    else $error("frame_end disagrees with kind");

  a_flush_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_FLUSH |->
      byte_value == 8'd0 && frame_type == 8'd0 && payload_length == 8'd0)
    else $error("flush result carries data");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> payload_index == 8'd0)
    else $error("payload index on non-payload item");

endmodule

bind length_checksum_frame_receiver_unit lcfr_checker u_lcfr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .kind           (kind),
  .byte_value     (byte_value),
  .payload_index  (payload_index),
  .frame_type     (frame_type),
  .payload_length (payload_length),
  .frame_end      (frame_end)
);

### sim/frame_result_checker.sv
// Checker for the frame receiver: predicts each result and compares it with the output channel.
`timescale 1ns / 1ps

module frame_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       flush,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] kind,
  input  logic [7:0] byte_value,
  input  logic [7:0] payload_index,
  input  logic [7:0] frame_type,
  input  logic [7:0] payload_length,
  input  logic       frame_end,
  output int         failures,
  output int         pending_results,
  output int         results_checked
);
  import lcfr_pkg::*;

  logic [7:0] rx_position;
  logic [7:0] rx_frame_length;
  logic [7:0] rx_sum;
  logic [7:0] rx_type;

  frame_result_t expected_results[$];
  int fail_total;
  int checked_total;

  function automatic void clear_frame_state();
    rx_position     = '0;
    rx_frame_length = '0;
    rx_sum          = '0;
    rx_type         = '0;
  endfunction

  function automatic frame_result_t classify_byte(input logic [7:0] b, input logic fl);
    frame_result_t r;
    r = '0;
    r.byte_value = b;
    if (fl) begin
      clear_frame_state();
      r.kind       = KIND_FLUSH;
      r.byte_value = '0;
      r.frame_end  = 1'b1;
    end else if (rx_position == 8'd0) begin
      if (b < LEN_MIN) begin
        r.kind      = KIND_SHORT;
        r.frame_end = 1'b1;
      end else begin
        r.kind           = KIND_LENGTH;
        rx_frame_length  = b;
        rx_sum           = b;
        rx_type          = '0;
        rx_position      = 8'd1;
        r.payload_length = b - LEN_MIN;
      end
    end else if (rx_position == 8'd1) begin
      r.kind           = KIND_TYPE;
      rx_type          = b;
      rx_sum           = rx_sum + b;
      rx_position      = 8'd2;
      r.frame_type     = b;
      r.payload_length = rx_frame_length - LEN_MIN;
    end else begin
      r.frame_type     = rx_type;
      r.payload_length = rx_frame_length - LEN_MIN;
      if ({1'b0, rx_position} + 9'd1 >= {1'b0, rx_frame_length}) begin
        r.kind      = (b == (rx_sum ^ SUM_INVERT)) ? KIND_GOOD : KIND_BAD;
        r.frame_end = 1'b1;
        clear_frame_state();
      end else begin
        r.kind          = KIND_PAYLOAD;
        r.payload_index = rx_position - 8'd2;
        rx_sum          = rx_sum + b;
        rx_position     = rx_position + 8'd1;
      end
    end
    return r;
  endfunction

  function automatic void note_failure(input string what);
    fail_total++;
    if (fail_total <= 10) $display("%0t: mismatch: %s", $time, what);
  endfunction

  always @(posedge clk) begin
    frame_result_t seen;
    frame_result_t want;
    if (rst) begin
      clear_frame_state();
      expected_results.delete();
      fail_total    = 0;
      checked_total = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen.kind           = kind;
        seen.byte_value     = byte_value;
        seen.payload_index  = payload_index;
        seen.frame_type     = frame_type;
        seen.payload_length = payload_length;
        seen.frame_end      = frame_end;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with none outstanding: kind %0d byte %02h",
                                 seen.kind, seen.byte_value));
        end else begin
          want = expected_results.pop_front();
          checked_total++;
          if (seen.kind != want.kind || seen.byte_value != want.byte_value ||
              seen.payload_index != want.payload_index ||
              seen.frame_type != want.frame_type ||
              seen.payload_length != want.payload_length ||
              seen.frame_end != want.frame_end) begin
            note_failure({
              $sformatf("exp kind %0d byte %02h idx %0d type %02h plen %0d end %0b",
                        want.kind, want.byte_value, want.payload_index, want.frame_type,
                        want.payload_length, want.frame_end),
              $sformatf(", got kind %0d byte %02h idx %0d type %02h plen %0d end %0b",
                        seen.kind, seen.byte_value, seen.payload_index, seen.frame_type,
                        seen.payload_length, seen.frame_end)});
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), classify_byte(rx_byte, flush));
      end
    end
    failures        <= fail_total;
    pending_results <= expected_results.size();
    results_checked <= checked_total;
  end

endmodule

### sim/tb_length_checksum_frame_receiver_unit.sv
// Testbench top for the frame receiver: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_length_checksum_frame_receiver_unit;

  localparam int ITEM_TARGET = 600;
  localparam int IDLE_LIMIT  = 4000;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte  = 8'd0;
  logic       flush    = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] byte_value;
  logic [7:0] payload_index;
  logic [7:0] frame_type;
  logic [7:0] payload_length;
  logic       frame_end;

  int failures;
  int pending_results;
  int results_checked;

  int items_sent   = 0;
  int frames_whole = 0;
  int frames_bad   = 0;
  int frames_cut   = 0;
  bit send_idle_on = 1'b0;
  bit stall_on     = 1'b0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  length_checksum_frame_receiver_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .flush          (flush),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .byte_value     (byte_value),
    .payload_index  (payload_index),
    .frame_type     (frame_type),
    .payload_length (payload_length),
    .frame_end      (frame_end)
  );

  frame_result_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .flush           (flush),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .byte_value      (byte_value),
    .payload_index   (payload_index),
    .frame_type      (frame_type),
    .payload_length  (payload_length),
    .frame_end       (frame_end),
    .failures        (failures),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 99) < 30) begin
      out_ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[length_checksum_frame_receiver_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic fl);
    int gap;
    gap = send_idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    flush    <= fl;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // keep: number of leading bytes to send; fewer than frame_len cuts the frame short
  task automatic send_frame(input int frame_len, input logic [7:0] ftype, input bit good,
                            input int keep);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] spoil;
    int i;
    sum = frame_len[7:0];
    for (i = 0; i < frame_len && i < keep; i++) begin
      if (i == 0) begin
        b = frame_len[7:0];
      end else if (i == 1) begin
        b = ftype;
      end else if (i == frame_len - 1) begin
        spoil = 8'($urandom_range(1, 255));
        b = good ? ~sum : (~sum ^ spoil);
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      if (i > 0 && i < frame_len - 1) sum = sum + b;
      put_byte(b, 1'b0);
    end
    if (keep >= frame_len) begin
      frames_whole++;
      if (!good) frames_bad++;
    end else begin
      frames_cut++;
    end
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  initial begin
    int r;
    int len;
    int next_mode_change;
    bit max_done;
    bit drained_mid;
    next_mode_change = 60;
    max_done         = 1'b0;
    drained_mid      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    put_byte(8'hAB, 1'b1);
    put_byte(8'd0, 1'b0);
    put_byte(8'd1, 1'b0);
    put_byte(8'd2, 1'b0);
    send_frame(3, 8'h00, 1'b1, 3);
    send_frame(3, 8'hFF, 1'b0, 3);
    send_frame(5, 8'hA5, 1'b1, 5);
    send_frame(6, 8'h5A, 1'b1, 2);
    put_byte(8'($urandom_range(0, 255)), 1'b1);
    send_frame(8, 8'h3C, 1'b1, 1);
    put_byte(8'hFF, 1'b1);
    send_frame(4, 8'h80, 1'b0, 4);
    wait_until_drained();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_mode_change) begin
        send_idle_on     = $urandom_range(0, 3) != 0;
        stall_on         = $urandom_range(0, 3) != 0;
        next_mode_change = next_mode_change + 60;
      end
      if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
        wait_until_drained();
        drained_mid = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (!max_done && items_sent >= 150) begin
        send_frame(255, 8'($urandom_range(0, 255)), 1'b1, 255);
        max_done = 1'b1;
      end else if (r < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
        send_frame(len, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0, len);
      end else if (r < 80) begin
        len = $urandom_range(4, 12);
        send_frame(len, 8'($urandom_range(0, 255)), 1'b1, $urandom_range(1, len - 1));
        put_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 88) begin
        put_byte(8'($urandom_range(0, 2)), 1'b0);
      end else if (r < 94) begin
        put_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        put_byte(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 1) != 0) put_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_until_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes: %0d whole frames (%0d with a bad checksum), %0d cut short by flush,",
             items_sent, frames_whole, frames_bad, frames_cut);
    $display("plus short lengths, stray bytes and one maximum-length frame; %0d results checked.",
             results_checked);
    if (failures == 0 && pending_results == 0) begin
      $display("[length_checksum_frame_receiver_unit] OK");
    end else begin
      $display("[length_checksum_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lcfr_pkg.sv
rtl/lcfr_step.sv
rtl/length_checksum_frame_receiver_unit.sv
rtl/lcfr_checker.sv
sim/frame_result_checker.sv
sim/tb_length_checksum_frame_receiver_unit.sv
